>>> rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// Scancode line editor package
// Event codes, scancode constants, the set-1 translation tables and the
// record types passed between the decoder and the top level.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam logic [1:0] EV_APPEND = 2'd0;
  localparam logic [1:0] EV_ERASE  = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;

  localparam logic [7:0] SC_ENTER       = 8'h1C;
  localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

  typedef struct packed {
    logic [1:0] event_res;
    logic [6:0] character;
    logic [7:0] position;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] num_results;
    result_t    first;
    result_t    second;
    logic       shift_next;
    logic [7:0] count_next;
  } decode_t;

  // US layout without shift. A zero means the key has no mapping.
  function automatic logic [6:0] plain_char(input logic [5:0] code);
    logic [6:0] ch;
    case (code)
      6'd2:  ch = 7'h31;  6'd3:  ch = 7'h32;  6'd4:  ch = 7'h33;
      6'd5:  ch = 7'h34;  6'd6:  ch = 7'h35;  6'd7:  ch = 7'h36;
      6'd8:  ch = 7'h37;  6'd9:  ch = 7'h38;  6'd10: ch = 7'h39;
      6'd11: ch = 7'h30;  6'd12: ch = 7'h2D;  6'd13: ch = 7'h3D;
      6'd16: ch = 7'h71;  6'd17: ch = 7'h77;  6'd18: ch = 7'h65;
      6'd19: ch = 7'h72;  6'd20: ch = 7'h74;  6'd21: ch = 7'h79;
      6'd22: ch = 7'h75;  6'd23: ch = 7'h69;  6'd24: ch = 7'h6F;
      6'd25: ch = 7'h70;  6'd26: ch = 7'h5B;  6'd27: ch = 7'h5D;
      6'd30: ch = 7'h61;  6'd31: ch = 7'h73;  6'd32: ch = 7'h64;
      6'd33: ch = 7'h66;  6'd34: ch = 7'h67;  6'd35: ch = 7'h68;
      6'd36: ch = 7'h6A;  6'd37: ch = 7'h6B;  6'd38: ch = 7'h6C;
      6'd39: ch = 7'h3B;  6'd40: ch = 7'h27;  6'd41: ch = 7'h60;
      6'd43: ch = 7'h5C;  6'd44: ch = 7'h7A;  6'd45: ch = 7'h78;
      6'd46: ch = 7'h63;  6'd47: ch = 7'h76;  6'd48: ch = 7'h62;
      6'd49: ch = 7'h6E;  6'd50: ch = 7'h6D;  6'd51: ch = 7'h2C;
      6'd52: ch = 7'h2E;  6'd53: ch = 7'h2F;  6'd57: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // US layout with shift held.
  function automatic logic [6:0] shift_char(input logic [5:0] code);
    logic [6:0] ch;
    case (code)
      6'd2:  ch = 7'h21;  6'd3:  ch = 7'h40;  6'd4:  ch = 7'h23;
      6'd5:  ch = 7'h24;  6'd6:  ch = 7'h25;  6'd7:  ch = 7'h5E;
      6'd8:  ch = 7'h26;  6'd9:  ch = 7'h2A;  6'd10: ch = 7'h28;
      6'd11: ch = 7'h29;  6'd12: ch = 7'h5F;  6'd13: ch = 7'h2B;
      6'd16: ch = 7'h51;  6'd17: ch = 7'h57;  6'd18: ch = 7'h45;
      6'd19: ch = 7'h52;  6'd20: ch = 7'h54;  6'd21: ch = 7'h59;
      6'd22: ch = 7'h55;  6'd23: ch = 7'h49;  6'd24: ch = 7'h4F;
      6'd25: ch = 7'h50;  6'd26: ch = 7'h7B;  6'd27: ch = 7'h7D;
      6'd30: ch = 7'h41;  6'd31: ch = 7'h53;  6'd32: ch = 7'h44;
      6'd33: ch = 7'h46;  6'd34: ch = 7'h47;  6'd35: ch = 7'h48;
      6'd36: ch = 7'h4A;  6'd37: ch = 7'h4B;  6'd38: ch = 7'h4C;
      6'd39: ch = 7'h3A;  6'd40: ch = 7'h22;  6'd41: ch = 7'h7E;
      6'd43: ch = 7'h7C;  6'd44: ch = 7'h5A;  6'd45: ch = 7'h58;
      6'd46: ch = 7'h43;  6'd47: ch = 7'h56;  6'd48: ch = 7'h42;
      6'd49: ch = 7'h4E;  6'd50: ch = 7'h4D;  6'd51: ch = 7'h3C;
      6'd52: ch = 7'h3E;  6'd53: ch = 7'h3F;  6'd57: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/sle_if.sv
// ----------------------------------------------------------------------------
// Scancode line editor channels
// Valid/ready channels for scancodes, editing events and the length register.
// ----------------------------------------------------------------------------
interface sle_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;

  modport source (output valid, output scancode, input ready);
  modport sink   (input valid, input scancode, output ready);
endinterface

interface sle_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [6:0] character;
  logic [7:0] position;
  logic       last;

  modport source (output valid, output event_res, output character,
                  output position, output last, input ready);
  modport sink   (input valid, input event_res, input character,
                  input position, input last, output ready);
endinterface

interface sle_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/sle_decode.sv
// ----------------------------------------------------------------------------
// Scancode line editor decoder
// Translates one scancode against the current shift flag and count into up
// to two editing events and the next editor state.
// ----------------------------------------------------------------------------
module sle_decode
  import sle_pkg::*;
(
  input  logic [7:0] scancode,
  input  logic       shift_held,
  input  logic [7:0] char_count,
  input  logic [7:0] max_length,
  output decode_t    dec
);

  logic [7:0] limit;
  logic [8:0] count_inc;
  logic [6:0] ch;

  assign limit     = (max_length == 8'd0) ? 8'd1 : max_length;
  assign count_inc = {1'b0, char_count} + 9'd1;
  assign ch        = shift_held ? shift_char(scancode[5:0]) : plain_char(scancode[5:0]);

  always_comb begin
    dec             = '0;
    dec.shift_next  = shift_held;
    dec.count_next  = char_count;
    if (scancode == SC_LSHIFT_MAKE) begin
      dec.shift_next = 1'b1;
    end else if (scancode == SC_LSHIFT_BRK) begin
      dec.shift_next = 1'b0;
    end else if (scancode == SC_ENTER) begin
      dec.num_results     = 2'd1;
      dec.first.event_res = EV_DONE;
      dec.first.position  = char_count;
      dec.first.last      = 1'b1;
      dec.count_next      = 8'd0;
      dec.shift_next      = 1'b0;
    end else if (scancode == SC_BACKSPACE) begin
      if (char_count != 8'd0) begin
        dec.num_results     = 2'd1;
        dec.first.event_res = EV_ERASE;
        dec.first.position  = char_count - 8'd1;
        dec.first.last      = 1'b1;
        dec.count_next      = char_count - 8'd1;
      end
    end else if (scancode[7:6] == 2'b00 && ch != 7'd0) begin
      dec.first.event_res = EV_APPEND;
      dec.first.character = ch;
      dec.first.position  = char_count;
      // The limit is compared with >= so that a lowered limit still ends the line.
      if (count_inc >= {1'b0, limit}) begin
        dec.num_results      = 2'd2;
        dec.first.last       = 1'b0;
        dec.second.event_res = EV_DONE;
        dec.second.position  = count_inc[7:0];
        dec.second.last      = 1'b1;
        dec.count_next       = 8'd0;
        dec.shift_next       = 1'b0;
      end else begin
        dec.num_results = 2'd1;
        dec.first.last  = 1'b1;
        dec.count_next  = count_inc[7:0];
      end
    end
  end

endmodule

>>> rtl/core/scancode_line_editor_unit.sv
// ----------------------------------------------------------------------------
// Scancode line editor
// Accepts one set-1 scancode per cycle while input ready is high and issues
// append, erase and line-complete events; the consumer keeps the text. Each
// scancode is decoded in the cycle it is accepted and its events (none, one,
// or an append followed by line complete) are written into a result queue of
// DEPTH entries, which drains one event per cycle while the consumer takes them.
// Input ready is held high while the queue has room for two events, so with a
// consumer taking every event the block sustains one scancode per cycle while
// each yields at most one event; an append that reaches max_length yields two.
// The max_length register (reset 255, zero acts as one) is set over the cfg channel.
// ----------------------------------------------------------------------------
module scancode_line_editor_unit
  import sle_pkg::*;
#(
  parameter int DEPTH = 4
)(
  input  logic              clk,
  input  logic              rst,
  sle_scan_if.sink          keys,
  sle_event_if.source       events,
  sle_cfg_if.sink           cfg
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       max_length;
  logic             shift_held;
  logic [7:0]       char_count;
  decode_t          dec;

  result_t          queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_take;
  logic             out_take;
  logic [1:0]       push_num;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  sle_decode u_decode (
    .scancode   (keys.scancode),
    .shift_held (shift_held),
    .char_count (char_count),
    .max_length (max_length),
    .dec        (dec)
  );

  assign cfg.ready  = 1'b1;
  assign keys.ready = (count <= CNT_W'(DEPTH - 2));
  assign in_take    = keys.valid && keys.ready;
  assign out_take   = events.valid && events.ready;
  assign push_num   = in_take ? dec.num_results : 2'd0;
  assign count_next = count + CNT_W'(push_num) - CNT_W'(out_take);

  assign events.valid     = (count != '0);
  assign events.event_res = queue[rd_ptr].event_res;
  assign events.character = queue[rd_ptr].character;
  assign events.position  = queue[rd_ptr].position;
  assign events.last      = queue[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
      shift_held <= 1'b0;
      char_count <= 8'd0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        max_length <= cfg.data;
      end
      if (in_take) begin
        shift_held <= dec.shift_next;
        char_count <= dec.count_next;
      end
      if (push_num == 2'd1) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end else if (push_num == 2'd2) begin
        wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
      end
      if (out_take) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      queue[wr_ptr] <= dec.first;
    end
    if (push_num == 2'd2) begin
      queue[ptr_inc(wr_ptr)] <= dec.second;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_enter_clears: assert property (@(posedge clk) disable iff (rst)
    (in_take && keys.scancode == SC_ENTER) |=> (char_count == 8'd0 && !shift_held))
    else $error("Enter did not clear the line state");

  a_backspace_dec: assert property (@(posedge clk) disable iff (rst)
    (in_take && keys.scancode == SC_BACKSPACE && char_count != 8'd0)
      |=> (char_count == $past(char_count) - 8'd1))
    else $error("backspace did not shorten the line");

  a_not_last_is_append: assert property (@(posedge clk) disable iff (rst)
    (events.valid && !events.last) |-> (events.event_res == EV_APPEND))
    else $error("only an append may be followed by another event");

endmodule

>>> sim/scancode_line_editor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scancode line editor checker
// Watches the scancode, event and length channels of the line editor. For
// each accepted scancode it works out the editing events that should follow.
// It compares every accepted event, field by field, with the oldest event
// still expected, and reports the mismatch and backlog counts to the bench.
// ----------------------------------------------------------------------------
module scancode_line_editor_checker
  import sle_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  sle_scan_if   keys,
  sle_event_if  events,
  sle_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding,
  output int    checked_events
);

  result_t    expected_events[$];
  logic [7:0] line_limit;
  logic [7:0] line_len;
  logic       shift_on;
  int         error_total;
  int         event_total;
  result_t    got;
  result_t    want;

  // Upper byte is the plain character, lower byte the shifted one.
  function automatic logic [15:0] key_glyphs(input logic [5:0] code);
    logic [15:0] pair;
    case (code)
      6'd2:  pair = "1!";   6'd3:  pair = "2@";   6'd4:  pair = "3#";
      6'd5:  pair = "4$";   6'd6:  pair = "5%";   6'd7:  pair = "6^";
      6'd8:  pair = "7&";   6'd9:  pair = "8*";   6'd10: pair = "9(";
      6'd11: pair = "0)";   6'd12: pair = "-_";   6'd13: pair = "=+";
      6'd16: pair = "qQ";   6'd17: pair = "wW";   6'd18: pair = "eE";
      6'd19: pair = "rR";   6'd20: pair = "tT";   6'd21: pair = "yY";
      6'd22: pair = "uU";   6'd23: pair = "iI";   6'd24: pair = "oO";
      6'd25: pair = "pP";   6'd26: pair = "[{";   6'd27: pair = "]}";
      6'd30: pair = "aA";   6'd31: pair = "sS";   6'd32: pair = "dD";
      6'd33: pair = "fF";   6'd34: pair = "gG";   6'd35: pair = "hH";
      6'd36: pair = "jJ";   6'd37: pair = "kK";   6'd38: pair = "lL";
      6'd39: pair = ";:";   6'd40: pair = "'\"";  6'd41: pair = "`~";
      6'd43: pair = "\\|";  6'd44: pair = "zZ";   6'd45: pair = "xX";
      6'd46: pair = "cC";   6'd47: pair = "vV";   6'd48: pair = "bB";
      6'd49: pair = "nN";   6'd50: pair = "mM";   6'd51: pair = ",<";
      6'd52: pair = ".>";   6'd53: pair = "/?";   6'd57: pair = "  ";
      default: pair = 16'h0000;
    endcase
    return pair;
  endfunction

  function automatic void queue_event(input logic [1:0] ev, input logic [6:0] ch,
                                      input logic [7:0] pos, input logic fin);
    result_t r;
    r.event_res = ev;
    r.character = ch;
    r.position  = pos;
    r.last      = fin;
    expected_events.push_back(r);
  endfunction

  // Updates the line state for one scancode request and queues its events.
  function automatic void take_scancode(input logic [7:0] code);
    logic [15:0] pair;
    logic [6:0]  ch;
    logic [8:0]  limit;
    limit = (line_limit == 8'd0) ? 9'd1 : {1'b0, line_limit};
    if (code == SC_LSHIFT_MAKE) begin
      shift_on = 1'b1;
    end else if (code == SC_LSHIFT_BRK) begin
      shift_on = 1'b0;
    end else if (code == SC_ENTER) begin
      queue_event(EV_DONE, 7'd0, line_len, 1'b1);
      line_len = 8'd0;
      shift_on = 1'b0;
    end else if (code == SC_BACKSPACE) begin
      if (line_len != 8'd0) begin
        line_len = line_len - 8'd1;
        queue_event(EV_ERASE, 7'd0, line_len, 1'b1);
      end
    end else if (code[7:6] == 2'b00) begin
      pair = key_glyphs(code[5:0]);
      ch = shift_on ? pair[6:0] : pair[14:8];
      if (ch != 7'd0) begin
        if ({1'b0, line_len} + 9'd1 >= limit) begin
          queue_event(EV_APPEND, ch, line_len, 1'b0);
          queue_event(EV_DONE, 7'd0, line_len + 8'd1, 1'b1);
          line_len = 8'd0;
          shift_on = 1'b0;
        end else begin
          queue_event(EV_APPEND, ch, line_len, 1'b1);
          line_len = line_len + 8'd1;
        end
      end
    end
  endfunction

  initial begin
    mismatches     = 0;
    outstanding    = 0;
    checked_events = 0;
    error_total    = 0;
    event_total    = 0;
    line_limit     = MAX_LENGTH_RESET;
    line_len       = 8'd0;
    shift_on       = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      line_limit = MAX_LENGTH_RESET;
      line_len   = 8'd0;
      shift_on   = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        line_limit = cfg.data;
      end
      // Predict before comparing.
      if (keys.valid && keys.ready) begin
        take_scancode(keys.scancode);
      end
      if (events.valid && events.ready) begin
        got.event_res = events.event_res;
        got.character = events.character;
        got.position  = events.position;
        got.last      = events.last;
        event_total++;
        if (expected_events.size() == 0) begin
          error_total++;
          if (error_total <= 10) begin
            $display("%0t: unexpected event ev=%0d ch=%02h pos=%0d last=%0d", $time,
                     got.event_res, got.character, got.position, got.last);
          end
        end else begin
          want = expected_events.pop_front();
          if (got.event_res != want.event_res || got.character != want.character ||
              got.position != want.position || got.last != want.last) begin
            error_total++;
            if (error_total <= 10) begin
              $display("%0t: event mismatch: expected ev=%0d ch=%02h pos=%0d last=%0d",
                       $time, want.event_res, want.character, want.position, want.last);
              $display("%0t:                 actual   ev=%0d ch=%02h pos=%0d last=%0d",
                       $time, got.event_res, got.character, got.position, got.last);
            end
          end
        end
      end
    end
    mismatches     <= error_total;
    outstanding    <= expected_events.size();
    checked_events <= event_total;
  end

endmodule

>>> sim/scancode_line_editor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scancode line editor testbench
// Drives directed and random scancode streams into the line editor under
// several length limits and several mixes of sender gaps and receiver
// stalls; a checker beside the block predicts and compares every event.
// ----------------------------------------------------------------------------
module scancode_line_editor_unit_tb
  import sle_pkg::*;
;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 70;
  localparam int LONG_LINE      = 260;

  localparam logic [7:0] OPENING_KEYS [19] = '{
    8'h00, 8'hFF, 8'h1E, 8'h02, 8'h39, 8'h35, SC_LSHIFT_MAKE, 8'h1E, 8'h2B,
    SC_ENTER, SC_BACKSPACE, 8'h10, SC_BACKSPACE, SC_ENTER, SC_LSHIFT_BRK,
    8'h36, 8'h9E, 8'h3A, 8'h1E
  };
  localparam logic [7:0] PHASE_LIMITS [NUM_PHASES] = '{
    8'd255, 8'd1, 8'd5, 8'd255, 8'd12, 8'd0, 8'd2, 8'd40
  };
  localparam int IDLE_PCT  [4] = '{0, 68, 0, 34};
  localparam int STALL_PCT [4] = '{0, 0, 68, 34};

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   keys_sent;
  int   length_writes;
  int   quiet_cycles;
  int   mismatches;
  int   outstanding;
  int   checked_events;

  sle_scan_if  keys_if ();
  sle_event_if ev_if ();
  sle_cfg_if   cfg_if ();

  scancode_line_editor_unit uut (
    .clk    (clk),
    .rst    (rst),
    .keys   (keys_if),
    .events (ev_if),
    .cfg    (cfg_if)
  );

  scancode_line_editor_checker line_checker (
    .clk            (clk),
    .rst            (rst),
    .keys           (keys_if),
    .events         (ev_if),
    .cfg            (cfg_if),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked_events (checked_events)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    ev_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Ends the run when nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (keys_if.valid && keys_if.ready) || (ev_if.valid && ev_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no channel activity for %0d cycles", WATCHDOG_LIMIT);
      $display("** scancode_line_editor_unit: FAILED **");
      $finish;
    end
  end

  // Keys that produce a character: 2..13, 16..27, 30..41, 43..53 and space.
  function automatic logic [7:0] printable_code();
    logic [7:0] code;
    do begin
      code = 8'($urandom_range(2, 57));
    end while (!((code <= 8'd13) || (code >= 8'd16 && code <= 8'd27) ||
                 (code >= 8'd30 && code <= 8'd41) || (code >= 8'd43 && code <= 8'd53) ||
                 code == 8'd57));
    return code;
  endfunction

  function automatic logic [7:0] random_scancode();
    int roll;
    roll = $urandom_range(99);
    if (roll < 58) return printable_code();
    else if (roll < 66) return SC_LSHIFT_MAKE;
    else if (roll < 73) return SC_LSHIFT_BRK;
    else if (roll < 82) return SC_BACKSPACE;
    else if (roll < 88) return SC_ENTER;
    else return 8'($urandom_range(255));
  endfunction

  // Valid stays high after a request so back-to-back requests need no toggle.
  task automatic send_key(input logic [7:0] code);
    if ($urandom_range(99) < idle_pct) begin
      keys_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    keys_if.valid    <= 1'b1;
    keys_if.scancode <= code;
    do @(posedge clk); while (!keys_if.ready);
    keys_sent++;
  endtask

  task automatic drain_events();
    keys_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // A request with no events may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [7:0] value);
    drain_events();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    length_writes++;
  endtask

  initial begin
    logic [7:0] limit;
    rst              = 1'b1;
    keys_if.valid    = 1'b0;
    keys_if.scancode = 8'h00;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = 8'h00;
    ev_if.ready      = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    keys_sent        = 0;
    length_writes    = 0;
    quiet_cycles     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit, then the smallest limits and a
    // limit dropped below the current line length.
    foreach (OPENING_KEYS[i]) send_key(OPENING_KEYS[i]);
    write_length(8'd1);
    send_key(8'h1E);
    write_length(8'd0);
    send_key(SC_LSHIFT_MAKE);
    send_key(8'h39);
    write_length(8'd255);
    send_key(8'h02);
    send_key(8'h03);
    send_key(8'h04);
    write_length(8'd2);
    send_key(8'h05);

    for (int p = 0; p < NUM_PHASES; p++) begin
      limit = (p == NUM_PHASES - 1) ? 8'($urandom_range(1, 255)) : PHASE_LIMITS[p];
      write_length(limit);
      idle_pct  = IDLE_PCT[p % 4];
      stall_pct = STALL_PCT[p % 4];
      // One unbroken line long enough to reach the largest limit.
      if (p == 3) begin
        repeat (LONG_LINE) send_key(printable_code());
      end
      repeat (PHASE_ITEMS) send_key(random_scancode());
    end

    drain_events();
    $display("Covered %0d scancodes and %0d length writes, limits 0 to 255,", keys_sent,
             length_writes);
    $display("under four gap/stall mixes; %0d events compared.", checked_events);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** scancode_line_editor_unit: PASSED **");
    end else begin
      $display("** scancode_line_editor_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sle_pkg.sv
rtl/core/sle_if.sv
rtl/core/sle_decode.sv
rtl/core/scancode_line_editor_unit.sv
sim/scancode_line_editor_checker.sv
sim/scancode_line_editor_unit_tb.sv
